[rtl/core/plids_pkg.sv]
// ----------------------------------------------------------------------------
// plids_pkg
// Shared types and constants of the positional list block: list depth,
// index widths, opcodes, status codes, sequencer states and the structs
// that pass between the sequencer, the compare unit and the top level.
// ----------------------------------------------------------------------------
package plids_pkg;

    localparam int DEPTH   = 16;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int OUT_W   = 5;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    // index and compare width: holds the count and the 5-bit position operand
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_WR,
        S_PUT,
        S_SRD,
        S_SCMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             dec;       // step direction: 1 down, 0 up
        logic             use_step;  // compare the stepped index instead of cmp_a
        logic [CMP_W-1:0] idx;
        logic [CMP_W-1:0] cmp_a;
        logic [CMP_W-1:0] cmp_b;
        logic [VAL_W-1:0] val_a;
        logic [VAL_W-1:0] val_b;
    } t_unit_req;

    typedef struct packed {
        logic [CMP_W-1:0] step;
        logic             lt;
        logic             eq;
    } t_unit_rsp;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        t_status          status;
        logic [OUT_W-1:0] found;
        logic [OUT_W-1:0] length;
    } t_result;

endpackage

[rtl/core/plids_ram.sv]
// ----------------------------------------------------------------------------
// plids_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module plids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/plids_unit.sv]
// ----------------------------------------------------------------------------
// plids_unit
// Shared step and compare unit: index increment or decrement, an index
// less-than compare and a 32-bit equality compare, reused every cycle.
// ----------------------------------------------------------------------------
module plids_unit (
    input  plids_pkg::t_unit_req i_req,
    output plids_pkg::t_unit_rsp o_rsp
);

    logic [plids_pkg::CMP_W-1:0] w_step;
    logic [plids_pkg::CMP_W-1:0] w_lhs;

    assign w_step = i_req.dec ? (i_req.idx - plids_pkg::CMP_W'(1))
                              : (i_req.idx + plids_pkg::CMP_W'(1));
    assign w_lhs  = i_req.use_step ? w_step : i_req.cmp_a;

    assign o_rsp.step = w_step;
    assign o_rsp.lt   = (w_lhs < i_req.cmp_b);
    assign o_rsp.eq   = (i_req.val_a == i_req.val_b);

endmodule

[rtl/core/plids_seq.sv]
// ----------------------------------------------------------------------------
// plids_seq
// Sequencer of the positional list: bounds checks, entry moves one at a
// time through the list RAM, linear search, and the list length.
// ----------------------------------------------------------------------------
module plids_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  plids_pkg::t_op                    i_op,
    input  logic [plids_pkg::VAL_W-1:0]       i_value,
    input  logic [plids_pkg::POS_W-1:0]       i_position,
    input  logic                              i_out_free,
    input  logic [plids_pkg::VAL_W-1:0]       i_rdata,
    output logic                              o_ready,
    output logic                              o_res_valid,
    output plids_pkg::t_result                o_result,
    output plids_pkg::t_ram_req               o_ram
);

    plids_pkg::t_state           r_state, n_state;
    plids_pkg::t_op              r_op, n_op;
    plids_pkg::t_status          r_status, n_status;
    logic [plids_pkg::VAL_W-1:0] r_val, n_val;
    logic [plids_pkg::CMP_W-1:0] r_pos, n_pos;
    logic [plids_pkg::CMP_W-1:0] r_idx, n_idx;
    logic [plids_pkg::CMP_W-1:0] r_count, n_count;
    logic [plids_pkg::OUT_W-1:0] r_found, n_found;

    plids_pkg::t_unit_req w_ureq;
    plids_pkg::t_unit_rsp w_ursp;

    logic w_full;
    logic w_ins_bad;
    logic w_del_bad;

    plids_unit u_unit (
        .i_req (w_ureq),
        .o_rsp (w_ursp)
    );

    assign w_full    = (r_count == plids_pkg::CMP_W'(plids_pkg::DEPTH));
    assign w_ins_bad = (r_pos > r_count);
    assign w_del_bad = (r_pos >= r_count);

    // unit operands
    always_comb begin
        w_ureq          = '0;
        w_ureq.idx      = r_idx;
        w_ureq.val_a    = i_rdata;
        w_ureq.val_b    = r_val;
        w_ureq.dec      = (r_op != plids_pkg::OP_DELETE) && (r_op != plids_pkg::OP_SEARCH);
        unique case (r_state)
            plids_pkg::S_RD: begin
                if (r_op == plids_pkg::OP_DELETE) begin
                    // more to move while idx + 1 < count
                    w_ureq.use_step = 1'b1;
                    w_ureq.cmp_b    = r_count;
                end else begin
                    // insert moves while pos < idx
                    w_ureq.cmp_a = r_pos;
                    w_ureq.cmp_b = r_idx;
                end
            end
            plids_pkg::S_SRD: begin
                w_ureq.cmp_a = r_idx;
                w_ureq.cmp_b = r_count;
            end
            default: begin
                w_ureq.cmp_a = r_idx;
                w_ureq.cmp_b = r_count;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plids_pkg::S_IDLE: begin
                if (i_start) n_state = plids_pkg::S_DECODE;
            end
            plids_pkg::S_DECODE: begin
                unique case (r_op)
                    plids_pkg::OP_APPEND: n_state = w_full ? plids_pkg::S_DONE : plids_pkg::S_RD;
                    plids_pkg::OP_INSERT: begin
                        n_state = (w_full || w_ins_bad) ? plids_pkg::S_DONE : plids_pkg::S_RD;
                    end
                    plids_pkg::OP_DELETE: n_state = w_del_bad ? plids_pkg::S_DONE : plids_pkg::S_RD;
                    plids_pkg::OP_SEARCH: n_state = plids_pkg::S_SRD;
                    default:              n_state = plids_pkg::S_DONE;
                endcase
            end
            plids_pkg::S_RD: begin
                if (w_ursp.lt) begin
                    n_state = plids_pkg::S_WR;
                end else if (r_op == plids_pkg::OP_DELETE) begin
                    n_state = plids_pkg::S_DONE;
                end else begin
                    n_state = plids_pkg::S_PUT;
                end
            end
            plids_pkg::S_WR:   n_state = plids_pkg::S_RD;
            plids_pkg::S_PUT:  n_state = plids_pkg::S_DONE;
            plids_pkg::S_SRD:  n_state = w_ursp.lt ? plids_pkg::S_SCMP : plids_pkg::S_DONE;
            plids_pkg::S_SCMP: n_state = w_ursp.eq ? plids_pkg::S_DONE : plids_pkg::S_SRD;
            plids_pkg::S_DONE: begin
                if (i_out_free) n_state = plids_pkg::S_IDLE;
            end
            default:           n_state = plids_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op     = r_op;
        n_val    = r_val;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_count  = r_count;
        n_status = r_status;
        n_found  = r_found;
        o_ram    = '0;
        unique case (r_state)
            plids_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op  = i_op;
                    n_val = i_value;
                    n_pos = plids_pkg::CMP_W'(i_position);
                end
            end
            plids_pkg::S_DECODE: begin
                n_status = plids_pkg::ST_DONE;
                n_found  = '1;
                unique case (r_op)
                    plids_pkg::OP_APPEND: begin
                        if (w_full) n_status = plids_pkg::ST_FULL;
                        n_pos = r_count;
                        n_idx = r_count;
                    end
                    plids_pkg::OP_INSERT: begin
                        if (w_full)         n_status = plids_pkg::ST_FULL;
                        else if (w_ins_bad) n_status = plids_pkg::ST_RANGE;
                        n_idx = r_count;
                    end
                    plids_pkg::OP_DELETE: begin
                        if (w_del_bad) n_status = plids_pkg::ST_RANGE;
                        n_idx = r_pos;
                    end
                    plids_pkg::OP_SEARCH: n_idx = '0;
                    default:              n_idx = r_idx;
                endcase
            end
            plids_pkg::S_RD: begin
                o_ram.re    = w_ursp.lt;
                o_ram.raddr = (r_op == plids_pkg::OP_DELETE) ? w_ursp.step[plids_pkg::IDX_W-1:0]
                                                             : w_ursp.step[plids_pkg::IDX_W-1:0];
                if (!w_ursp.lt && (r_op == plids_pkg::OP_DELETE)) begin
                    n_count = r_count - plids_pkg::CMP_W'(1);
                end
            end
            plids_pkg::S_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[plids_pkg::IDX_W-1:0];
                o_ram.wdata = i_rdata;
                n_idx       = w_ursp.step;
            end
            plids_pkg::S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_pos[plids_pkg::IDX_W-1:0];
                o_ram.wdata = r_val;
                n_count     = r_count + plids_pkg::CMP_W'(1);
            end
            plids_pkg::S_SRD: begin
                o_ram.re    = w_ursp.lt;
                o_ram.raddr = r_idx[plids_pkg::IDX_W-1:0];
            end
            plids_pkg::S_SCMP: begin
                if (w_ursp.eq) n_found = r_idx[plids_pkg::OUT_W-1:0];
                else           n_idx   = w_ursp.step;
            end
            plids_pkg::S_DONE: begin
                n_idx = r_idx;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plids_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_ready          = (r_state == plids_pkg::S_IDLE);
    assign o_res_valid      = (r_state == plids_pkg::S_DONE) && i_out_free;
    assign o_result.status  = r_status;
    assign o_result.found   = r_found;
    assign o_result.length  = r_count[plids_pkg::OUT_W-1:0];

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plids_pkg::CMP_W'(plids_pkg::DEPTH))
        else $error("list length above depth");

    a_ins_idx : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plids_pkg::S_RD && r_op != plids_pkg::OP_DELETE) |-> (r_idx >= r_pos))
        else $error("insert move index passed the insert position");

    a_del_idx : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plids_pkg::S_RD && r_op == plids_pkg::OP_DELETE) |-> (r_idx < r_count))
        else $error("delete move index outside the list");

    a_put_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plids_pkg::S_PUT) |-> (r_count < plids_pkg::CMP_W'(plids_pkg::DEPTH)))
        else $error("new entry written into a full list");

endmodule

[rtl/core/positional_list_insert_delete_search.sv]
// ----------------------------------------------------------------------------
// positional_list_insert_delete_search
// Ordered list of signed 32-bit values with append, insert, delete and
// search by position, one operation per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   slave channel (i_s_*) carries one operation per transaction: opcode,
//   value and position. master channel (o_m_*) returns one result per
//   operation: status, found index and list length after the operation.
//   one operation is in flight at a time; o_s_tready is high only while the
//   sequencer is idle. the list sits in a single-port-read RAM, so entries
//   are moved or compared one at a time through the RAM read port.
//   insert moves the entries at and after the position back by one,
//   delete moves the entries after the position forward by one, and
//   search compares entries in order from index 0 and stops at the first
//   match; error results are returned without any RAM access.
//   the result sits in an output register; a new operation is taken while
//   it waits. when the receiver stalls, the next result holds in the
//   sequencer and no further operation is accepted.
//   reset empties the list at once; list contents need no clearing.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [1:0] opcode, [33:2] item_value, [38:34] position, [39] zero
    input  logic [plids_pkg::S_DATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [1:0] status, [6:2] found_index, [11:7] length, [15:12] zero
    output logic [plids_pkg::M_DATA_W-1:0]     o_m_tdata
);

    logic                        w_start;
    logic                        w_ready;
    logic                        w_out_free;
    logic                        w_res_valid;
    plids_pkg::t_result          w_result;
    plids_pkg::t_ram_req         w_ram;
    logic [plids_pkg::VAL_W-1:0] w_rdata;

    logic                           r_m_valid, n_m_valid;
    logic [plids_pkg::M_DATA_W-1:0] r_m_data, n_m_data;

    assign w_start    = i_s_tvalid && w_ready;
    assign w_out_free = !r_m_valid || i_m_tready;

    plids_ram #(
        .WIDTH (plids_pkg::VAL_W),
        .DEPTH (plids_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    plids_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_op        (plids_pkg::t_op'(i_s_tdata[1:0])),
        .i_value     (i_s_tdata[33:2]),
        .i_position  (i_s_tdata[38:34]),
        .i_out_free  (w_out_free),
        .i_rdata     (w_rdata),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .o_result    (w_result),
        .o_ram       (w_ram)
    );

    // output register
    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (w_res_valid) begin
            n_m_valid = 1'b1;
            n_m_data  = {4'b0000, w_result.length, w_result.found, w_result.status};
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    assign o_s_tready = w_ready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

[sim/positional_list_insert_delete_search_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_search_tb
// Drives list operations into the slave stream with random gaps and random
// master back-pressure, predicts each result from a local copy of the list
// and compares status, found index and length field by field.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_search_tb;

    import plids_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 11;
    localparam int RANDOM_OPS  = 1850;
    localparam int DRAIN_CYC   = 48;
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        t_status    status;
        logic [4:0] found;
        logic [4:0] length;
    } t_list_result;

    class list_scoreboard;
        logic [VAL_W-1:0] entries [DEPTH];
        int               count;
        t_list_result     pending_q [$];

        function new();
            count = 0;
        endfunction

        function void insert_at(int p, logic [VAL_W-1:0] v);
            int i;
            for (i = count; i > p; i--)
                entries[i] = entries[i-1];
            entries[p] = v;
            count++;
        endfunction

        function void delete_at(int p);
            int i;
            for (i = p; i + 1 < count; i++)
                entries[i] = entries[i+1];
            count--;
        endfunction

        // apply one accepted operation to the list and queue its result
        function void note_op(t_op op, logic [VAL_W-1:0] val, logic [4:0] pos);
            t_list_result exp;
            int           i;
            exp.status = ST_DONE;
            exp.found  = 5'h1f;
            case (op)
                OP_APPEND: begin
                    if (count >= DEPTH) exp.status = ST_FULL;
                    else insert_at(count, val);
                end
                OP_INSERT: begin
                    if (count >= DEPTH) exp.status = ST_FULL;
                    else if (int'(pos) > count) exp.status = ST_RANGE;
                    else insert_at(int'(pos), val);
                end
                OP_DELETE: begin
                    if (int'(pos) >= count) exp.status = ST_RANGE;
                    else delete_at(int'(pos));
                end
                default: begin
                    // scan from the back so the first match wins
                    for (i = count - 1; i >= 0; i--)
                        if (entries[i] == val) exp.found = i[4:0];
                end
            endcase
            exp.length = count[4:0];
            pending_q.push_back(exp);
        endfunction

        function bit check_result(logic [M_DATA_W-1:0] data, output string msg);
            t_list_result got;
            t_list_result exp;
            got.status = t_status'(data[1:0]);
            got.found  = data[6:2];
            got.length = data[11:7];
            msg = "";
            if (pending_q.size() == 0) begin
                msg = $sformatf("result with no pending operation: status=%0d found=%0d len=%0d",
                                got.status, got.found, got.length);
                return 1'b0;
            end
            exp = pending_q.pop_front();
            if (got.status !== exp.status || got.found !== exp.found ||
                got.length !== exp.length || data[15:12] !== 4'd0) begin
                msg = $sformatf({"result mismatch: got status=%0d found=%0d len=%0d pad=%h, ",
                                 "expected status=%0d found=%0d len=%0d"},
                                got.status, got.found, got.length, data[15:12],
                                exp.status, exp.found, exp.length);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;

    list_scoreboard sb;
    int             mismatch_count = 0;
    int             stall_cycles   = 0;
    bit             no_idle        = 1'b0;

    positional_list_insert_delete_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic report(string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int idle_gap();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_op(t_op op, logic [VAL_W-1:0] val, logic [4:0] pos);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, pos, val, op};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_op(op, val, pos);
        @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 7);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: begin
                if (sb.count > 0) return sb.entries[$urandom_range(0, sb.count - 1)];
                return $urandom;
            end
        endcase
    endfunction

    task automatic run_directed();
        logic [VAL_W-1:0] v;
        int               k;
        send_op(OP_SEARCH, 32'd5, 5'd0);               // search in empty list
        send_op(OP_DELETE, 32'hffff_ffff, 5'd0);       // delete from empty list
        send_op(OP_DELETE, 32'h0, 5'd31);
        send_op(OP_INSERT, 32'h1111_1111, 5'd1);       // insert past the end
        send_op(OP_INSERT, 32'h7fff_ffff, 5'd0);
        send_op(OP_APPEND, 32'h8000_0000, 5'd31);      // position ignored
        send_op(OP_APPEND, 32'h0000_0000, 5'd0);
        send_op(OP_INSERT, 32'hffff_ffff, 5'd1);
        send_op(OP_INSERT, 32'h1234_5678, 5'(sb.count)); // insert at the end appends
        send_op(OP_INSERT, 32'h5555_aaaa, 5'(sb.count + 1));
        send_op(OP_SEARCH, 32'h8000_0000, 5'd31);
        send_op(OP_SEARCH, 32'h7fff_ffff, 5'd0);
        send_op(OP_SEARCH, 32'hdead_beef, 5'd7);
        send_op(OP_APPEND, 32'hffff_ffff, 5'd0);       // duplicate value
        send_op(OP_SEARCH, 32'hffff_ffff, 5'd0);
        send_op(OP_DELETE, 32'hffff_ffff, 5'd0);
        send_op(OP_DELETE, 32'h0, 5'(sb.count - 1));
        send_op(OP_DELETE, 32'h0, 5'd16);
        k = 0;
        while (sb.count < DEPTH) begin
            v = k[0] ? 32'h8000_0000 + k : 32'h7fff_ffff - k;
            send_op(OP_APPEND, v, 5'(k));
            k++;
        end
        send_op(OP_APPEND, 32'h0bad_f00d, 5'd0);       // append to full list
        send_op(OP_INSERT, 32'h0bad_f00d, 5'd31);      // full wins over range
        send_op(OP_INSERT, 32'h0bad_f00d, 5'd3);
        send_op(OP_SEARCH, sb.entries[DEPTH-1], 5'd0);
        send_op(OP_DELETE, 32'h0, 5'd16);
        send_op(OP_DELETE, 32'h0, 5'd15);
    endtask

    task automatic run_random(int n);
        int               j;
        int               roll;
        bit               growing;
        t_op              op;
        logic [VAL_W-1:0] v;
        logic [4:0]       p;
        growing = 1'b0;
        for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 79) == 0) no_idle = ~no_idle;
            // sweep the length back and forth between empty and full
            if (sb.count == 0) growing = 1'b1;
            else if (sb.count == DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
            else if ($urandom_range(0, 49) == 0) growing = ~growing;
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                op = t_op'($urandom_range(0, 3));
                v  = $urandom;
                p  = 5'($urandom_range(0, 31));
            end else begin
                roll = $urandom_range(0, 99);
                if (growing)
                    op = roll < 35 ? OP_APPEND : roll < 65 ? OP_INSERT :
                         roll < 80 ? OP_DELETE : OP_SEARCH;
                else
                    op = roll < 10 ? OP_APPEND : roll < 25 ? OP_INSERT :
                         roll < 65 ? OP_DELETE : OP_SEARCH;
                v = pick_value();
                case (op)
                    OP_INSERT: p = 5'($urandom_range(0, sb.count));
                    OP_DELETE: p = sb.count > 0 ? 5'($urandom_range(0, sb.count - 1)) : 5'd0;
                    default:   p = 5'($urandom_range(0, 31));
                endcase
                if ($urandom_range(0, 19) == 0) p = 5'($urandom_range(0, 31));
            end
            send_op(op, v, p);
        end
    endtask

    // receiver with random back-pressure
    initial begin
        int    gap;
        string msg;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = idle_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            if (!sb.check_result(o_m_tdata, msg)) report(msg);
            @(negedge i_clk);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        sb = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        run_random(RANDOM_OPS);
        i_s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_count == 0 && sb.pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
